// ===== design/ssv_pkg.sv =====
// Shared types, constants and the sine table function for the step sequencer.
// Used by every module of the block; depends on nothing.
package ssv_pkg;

    localparam int MAX_STEPS_DEF       = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF      = 32;

    localparam int TEMPO_W   = 9;
    localparam int RATE_W    = 18;
    localparam int ND_W      = 16;
    localparam int STEPS_W   = 5;
    localparam int LEN_W     = 22;
    localparam int FREQ_W    = 15;
    localparam int SAMPLE_W  = 18;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int DEN_W     = 18;
    localparam int SINE_W    = 16;

    localparam int TEMPO_MAX   = 300;
    localparam int SEC_PER_MIN = 60;
    localparam int TEMPO_RESET = 120;
    localparam int RATE_RESET  = 44100;
    localparam int ND_RESET    = 22050;
    localparam int STEPS_RESET = 16;
    localparam int STEP_LEN_RESET = 2 * ((RATE_RESET * SEC_PER_MIN) / (TEMPO_RESET * 8));

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 18'sh1FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 18'sh20000;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TEMPO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS = 2'd3;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_SET   = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [3:0]        voice_step;
        logic [FREQ_W-1:0] voice_frequency;
        logic              voice_enable;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       step_started;
        logic [3:0]                 started_step;
    } out_item_t;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
        logic       trig_en;
        logic       set_audible;
    } eng_ctrl_t;

    // Quarter-wave polynomial mirrored into four quadrants, Q1.15.
    function automatic logic signed [SINE_W-1:0] sine_value(input int unsigned addr,
                                                            input int unsigned tbits);
        longint unsigned qb;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned t;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned y;
        logic signed [SINE_W-1:0] v;
        qb   = longint'(tbits) - 2;
        quad = (longint'(addr) >> qb) & 64'd3;
        r    = longint'(addr) & ((64'd1 << qb) - 64'd1);
        t    = r << (64'd16 - qb);
        if (quad == 64'd1 || quad == 64'd3) begin
            t = 64'd65536 - t;
        end
        x2 = (t * t) >> 16;
        p  = (64'd4640 * x2) >> 16;
        p  = 64'd42047 - p;
        p  = (p * x2) >> 16;
        p  = 64'd102944 - p;
        y  = (t * p) >> 16;
        y  = (y + 64'd1) >> 1;
        if (y > 64'd32767) begin
            y = 64'd32767;
        end
        v = SINE_W'(y);
        return (quad >= 64'd2) ? -v : v;
    endfunction

endpackage

// ===== design/ssv_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on ssv_pkg for the divisor width.
module ssv_divider #(
    parameter int DW = 48
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DW-1:0]            dividend,
    input  logic [ssv_pkg::DEN_W-1:0] divisor,
    output logic                     done,
    output logic [DW-1:0]            quotient
);
    localparam int CNT_W = $clog2(DW + 1);

    logic                      busy_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      done_reg;
    logic [DW-1:0]             quo_reg;
    logic [ssv_pkg::DEN_W-1:0] rem_reg;
    logic [ssv_pkg::DEN_W-1:0] div_reg;
    logic [ssv_pkg::DEN_W:0]   rem_sh;
    logic                      ge;
    logic [ssv_pkg::DEN_W-1:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DW-1]};
        ge       = rem_sh >= {1'b0, div_reg};
        rem_next = ge ? ssv_pkg::DEN_W'(rem_sh - {1'b0, div_reg})
                      : ssv_pkg::DEN_W'(rem_sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== design/ssv_voice_engine.sv =====
// Voice state memories and the per-voice read-modify-write pipeline with the sine ROM and mixer.
// Depends on ssv_pkg.
module ssv_voice_engine #(
    parameter int MAX_STEPS       = ssv_pkg::MAX_STEPS_DEF,
    parameter int SINE_TABLE_BITS = ssv_pkg::SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = ssv_pkg::PHASE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ssv_pkg::eng_ctrl_t          ctrl,
    input  logic [$clog2(MAX_STEPS)-1:0] trig_idx,
    input  logic [$clog2(MAX_STEPS)-1:0] set_idx,
    input  logic [PHASE_BITS-1:0]       set_inc,
    input  logic [ssv_pkg::ND_W-1:0]    nd,
    output logic                        done,
    output logic signed [33+$clog2(MAX_STEPS)-1:0] sum
);
    localparam int IDX_W = $clog2(MAX_STEPS);
    localparam int TBL   = 2 ** SINE_TABLE_BITS;
    localparam int SUM_W = 33 + IDX_W;
    localparam int A_W   = PHASE_BITS + 1;
    localparam int B_W   = PHASE_BITS + ssv_pkg::ND_W;
    localparam int ND_W  = ssv_pkg::ND_W;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_INIT  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    logic [A_W-1:0] mem_a [MAX_STEPS];
    logic [B_W-1:0] mem_b [MAX_STEPS];
    logic signed [ssv_pkg::SINE_W-1:0] sine_rom [TBL];

    for (genvar g = 0; g < TBL; g++)
    begin : g_rom
        assign sine_rom[g] = ssv_pkg::sine_value(g, SINE_TABLE_BITS);
    end

    logic [1:0]       mode_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic             issuing_reg;
    logic             trig_en_reg;
    logic [IDX_W-1:0] trig_idx_reg;
    logic             done_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic             s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic             s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s2_use_reg, s3_use_reg;
    logic [SINE_TABLE_BITS-1:0] s2_addr_reg;
    logic [ND_W-1:0]  s2_w_reg, s3_w_reg;
    logic signed [ssv_pkg::SINE_W-1:0] s3_sine_reg;
    logic signed [32:0] s4_prod_reg;
    logic signed [32:0] prod;

    logic [A_W-1:0] a_q;
    logic [B_W-1:0] b_q;

    logic             a_we, b_we;
    logic [IDX_W-1:0] a_wa, b_wa;
    logic [A_W-1:0]   a_wd;
    logic [B_W-1:0]   b_wd;

    logic [PHASE_BITS-1:0] ph, ph_n;
    logic [ND_W-1:0]       age, age_n;
    logic                  sounding;
    logic                  cnt_last;
    logic                  set_now;

    assign cnt_last = cnt_reg == IDX_W'(MAX_STEPS - 1);
    assign set_now  = mode_reg == MODE_IDLE && ctrl.start && ctrl.op == ssv_pkg::OP_SET;

    always_comb
    begin
        ph  = b_q[B_W-1:ND_W];
        age = b_q[ND_W-1:0];
        if (trig_en_reg && s1_idx_reg == trig_idx_reg)
        begin
            ph  = '0;
            age = '0;
        end
        sounding = age < nd;
        ph_n     = sounding ? ph + a_q[A_W-1:1] : ph;
        age_n    = sounding ? age + 1'b1 : age;
    end

    always_comb
    begin
        a_we = 1'b0;
        a_wa = cnt_reg;
        a_wd = {{PHASE_BITS{1'b0}}, 1'b1};
        b_we = 1'b0;
        b_wa = cnt_reg;
        b_wd = {{PHASE_BITS{1'b0}}, nd};
        if (mode_reg == MODE_INIT)
        begin
            a_we = 1'b1;
            b_we = 1'b1;
        end
        else if (mode_reg == MODE_CLEAR)
        begin
            b_we = 1'b1;
        end
        else if (set_now)
        begin
            a_we = 1'b1;
            a_wa = set_idx;
            a_wd = {set_inc, ctrl.set_audible};
            b_we = 1'b1;
            b_wa = set_idx;
        end
        else if (s1_v_reg)
        begin
            b_we = 1'b1;
            b_wa = s1_idx_reg;
            b_wd = {ph_n, age_n};
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[a_wa] <= a_wd;
        end
        a_q <= mem_a[cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            mem_b[b_wa] <= b_wd;
        end
        b_q <= mem_b[cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            cnt_reg     <= '0;
            issuing_reg <= 1'b0;
            trig_en_reg <= 1'b0;
            done_reg    <= 1'b0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        cnt_reg <= '0;
                        unique case (ctrl.op)
                            ssv_pkg::OP_INIT:  mode_reg <= MODE_INIT;
                            ssv_pkg::OP_CLEAR: mode_reg <= MODE_CLEAR;
                            ssv_pkg::OP_TICK:
                            begin
                                mode_reg    <= MODE_TICK;
                                issuing_reg <= 1'b1;
                                trig_en_reg <= ctrl.trig_en;
                            end
                            default: mode_reg <= MODE_IDLE;
                        endcase
                    end
                end
                MODE_INIT, MODE_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_last)
                    begin
                        cnt_reg  <= '0;
                        mode_reg <= MODE_IDLE;
                        done_reg <= 1'b1;
                    end
                end
                MODE_TICK:
                begin
                    if (issuing_reg)
                    begin
                        s1_v_reg <= 1'b1;
                        cnt_reg  <= cnt_reg + 1'b1;
                        if (cnt_last)
                        begin
                            cnt_reg     <= '0;
                            issuing_reg <= 1'b0;
                        end
                    end
                    if (s4_v_reg && s4_last_reg)
                    begin
                        mode_reg <= MODE_IDLE;
                        done_reg <= 1'b1;
                    end
                end
                default: mode_reg <= MODE_IDLE;
            endcase
        end
    end

    assign prod = s3_sine_reg * $signed({1'b0, s3_w_reg});

    always_ff @(posedge clk)
    begin
        if (mode_reg == MODE_IDLE && ctrl.start)
        begin
            trig_idx_reg <= trig_idx;
            sum_reg      <= '0;
        end
        else if (s4_v_reg)
        begin
            sum_reg <= sum_reg + {{(SUM_W-33){s4_prod_reg[32]}}, s4_prod_reg};
        end
        s1_idx_reg  <= cnt_reg;
        s1_last_reg <= cnt_last;
        s2_last_reg <= s1_last_reg;
        s2_use_reg  <= sounding && a_q[0];
        s2_addr_reg <= ph_n[PHASE_BITS-1 -: SINE_TABLE_BITS];
        s2_w_reg    <= nd - age_n;
        s3_last_reg <= s2_last_reg;
        s3_use_reg  <= s2_use_reg;
        s3_w_reg    <= s2_w_reg;
        s3_sine_reg <= sine_rom[s2_addr_reg];
        s4_last_reg <= s3_last_reg;
        s4_prod_reg <= s3_use_reg ? prod : 33'sd0;
    end

    assign done = done_reg;
    assign sum  = sum_reg;
endmodule

// ===== design/step_sequencer_sine_voices_core.sv =====
// Step sequencer with one sine voice per step: control, configuration and output register.
// Depends on ssv_pkg, ssv_divider and ssv_voice_engine.
//
// A tick transaction walks every voice through the voice memories, one voice per cycle,
// and then divides the mix by four times the envelope length in the shared bit-serial
// divider, DW being max(PHASE_BITS + 15, 35 + log2(MAX_STEPS)) quotient bits, one per
// cycle. A set-voice transaction runs the pitch division in the divider (skipped when
// sample_rate is zero), and a start transaction runs a pass that silences the voices.
// After reset a pass initializes the voice memories before the first transaction is
// taken. A write to tempo or sample_rate recomputes the step length in the divider,
// during which input transactions are held off. Results wait in an output register, and
// the next transaction is accepted while a result is still waiting.
module step_sequencer_sine_voices_core #(
    parameter int MAX_STEPS       = ssv_pkg::MAX_STEPS_DEF,
    parameter int SINE_TABLE_BITS = ssv_pkg::SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = ssv_pkg::PHASE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  ssv_pkg::in_item_t               item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output ssv_pkg::out_item_t              result,
    input  logic                            cfg_we,
    input  logic [ssv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssv_pkg::CFG_W-1:0]       cfg_data
);
    localparam int IDX_W = $clog2(MAX_STEPS);
    localparam int SUM_W = 33 + IDX_W;
    localparam int NUM_W = SUM_W + 1;
    localparam int DW_A  = PHASE_BITS + ssv_pkg::FREQ_W;
    localparam int DW    = (DW_A > NUM_W + 1) ? DW_A : NUM_W + 1;
    localparam int CW    = 8;
    localparam int LEN_W = ssv_pkg::LEN_W;
    localparam int DEN_W = ssv_pkg::DEN_W;
    localparam int SW    = ssv_pkg::SAMPLE_W;

    localparam logic [3:0] ST_BOOT   = 4'd0;
    localparam logic [3:0] ST_WAIT   = 4'd1;
    localparam logic [3:0] ST_IDLE   = 4'd2;
    localparam logic [3:0] ST_LEN    = 4'd3;
    localparam logic [3:0] ST_SETDIV = 4'd4;
    localparam logic [3:0] ST_TICK   = 4'd5;
    localparam logic [3:0] ST_NUM    = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [ssv_pkg::TEMPO_W-1:0] tempo_reg, tempo_next;
    logic [ssv_pkg::RATE_W-1:0]  rate_reg, rate_next;
    logic [ssv_pkg::ND_W-1:0]    nd_reg, nd_next;
    logic [ssv_pkg::STEPS_W-1:0] steps_reg, steps_next;
    logic                        len_pending_reg, len_pending_next;
    logic                        running_reg, running_next;
    logic [IDX_W-1:0]            pos_reg, pos_next;
    logic [LEN_W-1:0]            sis_reg, sis_next;
    logic [LEN_W-1:0]            len_reg, len_next;
    logic                        started_reg, started_next;
    logic [IDX_W-1:0]            trig_reg, trig_next;
    logic [IDX_W-1:0]            set_idx_reg, set_idx_next;
    logic                        set_aud_reg, set_aud_next;
    logic signed [NUM_W-1:0]     num_reg, num_next;
    logic                        neg_reg, neg_next;
    logic signed [SW-1:0]        mix_reg, mix_next;
    logic                        result_valid_reg, result_valid_next;
    ssv_pkg::out_item_t          result_reg, result_next;

    ssv_pkg::eng_ctrl_t          eng_ctrl;
    logic [IDX_W-1:0]            eng_set_idx;
    logic [PHASE_BITS-1:0]       eng_set_inc;
    logic                        eng_done;
    logic signed [SUM_W-1:0]     eng_sum;

    logic                        div_start;
    logic [DW-1:0]               div_dividend;
    logic [DEN_W-1:0]            div_divisor;
    logic                        div_done;
    logic [DW-1:0]               div_quotient;

    logic                        accept;
    logic                        boundary;
    logic [CW-1:0]               limit;
    logic [CW-1:0]               pos_inc;
    logic [LEN_W-1:0]            sis_inc;
    logic [ssv_pkg::TEMPO_W-1:0] tempo_c;
    logic [DEN_W-1:0]            den;
    logic [NUM_W:0]              mag;

    assign item_stall = state_reg != ST_IDLE || len_pending_reg;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        boundary = len_reg != '0 && sis_reg == '0;
        limit    = (CW'(steps_reg) > CW'(MAX_STEPS)) ? CW'(MAX_STEPS) : CW'(steps_reg);
        pos_inc  = CW'(pos_reg) + 1'b1;
        sis_inc  = sis_reg + 1'b1;
        if (tempo_reg == '0)
        begin
            tempo_c = ssv_pkg::TEMPO_W'(1);
        end
        else if (tempo_reg > ssv_pkg::TEMPO_W'(ssv_pkg::TEMPO_MAX))
        begin
            tempo_c = ssv_pkg::TEMPO_W'(ssv_pkg::TEMPO_MAX);
        end
        else
        begin
            tempo_c = tempo_reg;
        end
        den = {nd_reg, 2'b00};
        if (num_reg[NUM_W-1])
        begin
            mag = {1'b0, ~num_reg} + (NUM_W+1)'(den);
        end
        else
        begin
            mag = {1'b0, num_reg};
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        tempo_next        = tempo_reg;
        rate_next         = rate_reg;
        nd_next           = nd_reg;
        steps_next        = steps_reg;
        len_pending_next  = len_pending_reg;
        running_next      = running_reg;
        pos_next          = pos_reg;
        sis_next          = sis_reg;
        len_next          = len_reg;
        started_next      = started_reg;
        trig_next         = trig_reg;
        set_idx_next      = set_idx_reg;
        set_aud_next      = set_aud_reg;
        num_next          = num_reg;
        neg_next          = neg_reg;
        mix_next          = mix_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;

        eng_ctrl          = '0;
        eng_set_idx       = set_idx_reg;
        eng_set_inc       = div_quotient[PHASE_BITS-1:0];
        div_start         = 1'b0;
        div_dividend      = DW'(ssv_pkg::FREQ_W'(item.voice_frequency)) << PHASE_BITS;
        div_divisor       = rate_reg;

        unique case (state_reg)
            ST_BOOT:
            begin
                eng_ctrl.start = 1'b1;
                eng_ctrl.op    = ssv_pkg::OP_INIT;
                state_next     = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (eng_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (len_pending_reg)
                begin
                    div_start        = 1'b1;
                    div_dividend     = DW'(rate_reg) * DW'(ssv_pkg::SEC_PER_MIN);
                    div_divisor      = DEN_W'({tempo_c, 3'b000});
                    len_pending_next = 1'b0;
                    state_next       = ST_LEN;
                end
                else if (accept)
                begin
                    unique case (item.kind)
                        ssv_pkg::KIND_SET:
                        begin
                            if (CW'(item.voice_step) < CW'(MAX_STEPS))
                            begin
                                set_idx_next = IDX_W'(item.voice_step);
                                set_aud_next = item.voice_enable;
                                if (rate_reg == '0)
                                begin
                                    eng_ctrl.start       = 1'b1;
                                    eng_ctrl.op          = ssv_pkg::OP_SET;
                                    eng_ctrl.set_audible = item.voice_enable;
                                    eng_set_idx          = IDX_W'(item.voice_step);
                                    eng_set_inc          = '0;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = ST_SETDIV;
                                end
                            end
                        end
                        ssv_pkg::KIND_START:
                        begin
                            eng_ctrl.start = 1'b1;
                            eng_ctrl.op    = ssv_pkg::OP_CLEAR;
                            pos_next       = '0;
                            sis_next       = '0;
                            running_next   = 1'b1;
                            state_next     = ST_WAIT;
                        end
                        ssv_pkg::KIND_STOP:
                        begin
                            running_next = 1'b0;
                        end
                        ssv_pkg::KIND_TICK:
                        begin
                            if (running_reg)
                            begin
                                eng_ctrl.start   = 1'b1;
                                eng_ctrl.op      = ssv_pkg::OP_TICK;
                                eng_ctrl.trig_en = boundary;
                                started_next     = boundary;
                                trig_next        = pos_reg;
                                if (boundary)
                                begin
                                    pos_next = (pos_inc >= limit) ? '0 : IDX_W'(pos_inc);
                                end
                                if (len_reg != '0)
                                begin
                                    sis_next = (sis_inc >= len_reg) ? '0 : sis_inc;
                                end
                                else
                                begin
                                    sis_next = '0;
                                end
                                state_next = ST_TICK;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LEN:
            begin
                if (div_done)
                begin
                    len_next   = {div_quotient[LEN_W-2:0], 1'b0};
                    state_next = ST_IDLE;
                end
            end
            ST_SETDIV:
            begin
                if (div_done)
                begin
                    eng_ctrl.start       = 1'b1;
                    eng_ctrl.op          = ssv_pkg::OP_SET;
                    eng_ctrl.set_audible = set_aud_reg;
                    state_next           = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (eng_done)
                begin
                    num_next = $signed({eng_sum[SUM_W-1], eng_sum})
                             + $signed({{(NUM_W-ssv_pkg::ND_W-1){1'b0}}, nd_reg, 1'b0});
                    state_next = ST_NUM;
                end
            end
            ST_NUM:
            begin
                neg_next = num_reg[NUM_W-1];
                if (nd_reg == '0)
                begin
                    mix_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (!neg_reg)
                    begin
                        mix_next = (div_quotient > DW'(131071)) ? ssv_pkg::SAMPLE_MAX
                                                                : $signed(div_quotient[SW-1:0]);
                    end
                    else
                    begin
                        mix_next = (div_quotient > DW'(131072)) ? ssv_pkg::SAMPLE_MIN
                                 : $signed(SW'(0) - div_quotient[SW-1:0]);
                    end
                    state_next = ST_OUT;
                end
                else if (!div_start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next        = 1'b1;
                    result_next.sample_out   = mix_reg;
                    result_next.step_started = started_reg;
                    result_next.started_step = started_reg ? 4'(trig_reg) : 4'd0;
                    state_next               = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // The mix division is launched on the cycle the state moves to ST_DIV.
        if (state_reg == ST_NUM && nd_reg != '0)
        begin
            div_start    = 1'b1;
            div_dividend = DW'(mag);
            div_divisor  = den;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                ssv_pkg::REG_TEMPO:
                begin
                    tempo_next       = cfg_data[ssv_pkg::TEMPO_W-1:0];
                    len_pending_next = 1'b1;
                end
                ssv_pkg::REG_RATE:
                begin
                    rate_next        = cfg_data[ssv_pkg::RATE_W-1:0];
                    len_pending_next = 1'b1;
                end
                ssv_pkg::REG_DUR:   nd_next    = cfg_data[ssv_pkg::ND_W-1:0];
                ssv_pkg::REG_STEPS: steps_next = cfg_data[ssv_pkg::STEPS_W-1:0];
                default:            nd_next    = nd_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_BOOT;
            tempo_reg        <= ssv_pkg::TEMPO_W'(ssv_pkg::TEMPO_RESET);
            rate_reg         <= ssv_pkg::RATE_W'(ssv_pkg::RATE_RESET);
            nd_reg           <= ssv_pkg::ND_W'(ssv_pkg::ND_RESET);
            steps_reg        <= ssv_pkg::STEPS_W'(ssv_pkg::STEPS_RESET);
            len_pending_reg  <= 1'b0;
            running_reg      <= 1'b0;
            pos_reg          <= '0;
            sis_reg          <= '0;
            len_reg          <= LEN_W'(ssv_pkg::STEP_LEN_RESET);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tempo_reg        <= tempo_next;
            rate_reg         <= rate_next;
            nd_reg           <= nd_next;
            steps_reg        <= steps_next;
            len_pending_reg  <= len_pending_next;
            running_reg      <= running_next;
            pos_reg          <= pos_next;
            sis_reg          <= sis_next;
            len_reg          <= len_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        started_reg <= started_next;
        trig_reg    <= trig_next;
        set_idx_reg <= set_idx_next;
        set_aud_reg <= set_aud_next;
        num_reg     <= num_next;
        neg_reg     <= neg_next;
        mix_reg     <= mix_next;
        result_reg  <= result_next;
    end

    ssv_divider #(
        .DW(DW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    ssv_voice_engine #(
        .MAX_STEPS       (MAX_STEPS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (eng_ctrl),
        .trig_idx (pos_reg),
        .set_idx  (eng_set_idx),
        .set_inc  (eng_set_inc),
        .nd       (nd_reg),
        .done     (eng_done),
        .sum      (eng_sum)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
endmodule
